/* rtl/svrm_pkg.sv */
// shared types, constants and codes of the sample voice resampling mixer
package svrm_pkg;

    // default sizing of the voice
    localparam int DEF_MAX_SAMPLES = 4096;
    localparam int DEF_SAMPLE_BITS = 16;
    localparam int DEF_FRAC_BITS   = 16;

    // fixed field widths
    localparam int LEN_W      = 13;
    localparam int STEP_W     = 24;
    localparam int GAIN_W     = 16;
    localparam int PAN_W      = 16;
    localparam int DELAY_W    = 16;
    localparam int MODE_W     = 2;
    localparam int IDX_IN_W   = 12;
    localparam int VAL_IN_W   = 16;
    localparam int OUT_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // pan arithmetic: unity is 2^15, the summed pan needs two guard bits
    localparam int PAN_SUM_W  = PAN_W + 2;
    localparam int WEIGHT_W   = PAN_W + 1;
    localparam int PAN_ONE    = 32768;
    localparam int MIX_SHIFT  = 30;

    // input mode codes
    localparam logic [MODE_W-1:0] MODE_WRITE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_START  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RENDER = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_ENABLE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN          = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VOICE_PAN     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_PAN   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BALANCE       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LEAD_IN       = 3'd7;

    // register reset values
    localparam logic [LEN_W-1:0]   RST_SAMPLE_LENGTH = 13'd1;
    localparam logic [STEP_W-1:0]  RST_STEP          = 24'd65536;
    localparam logic [GAIN_W-1:0]  RST_GAIN          = 16'd16384;

    // configuration register file contents
    typedef struct packed {
        logic [LEN_W-1:0]          sample_length;
        logic                      loop_enable;
        logic [STEP_W-1:0]         step;
        logic [GAIN_W-1:0]         gain;
        logic signed [PAN_W-1:0]   voice_pan;
        logic signed [PAN_W-1:0]   channel_pan;
        logic signed [PAN_W-1:0]   balance;
        logic [DELAY_W-1:0]        lead_in;
    } t_cfg;

    // controller to datapath commands
    typedef struct packed {
        logic accept;
        logic check;
        logic read;
        logic interp;
        logic scale;
        logic mix;
        logic load_out;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic frame_silent;
    } t_status;

endpackage

/* rtl/svrm_if.sv */
// handshake channel interfaces for input items and result frames
interface svrm_in_if;
    import svrm_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [MODE_W-1:0]          mode;
    logic [IDX_IN_W-1:0]        sample_index;
    logic signed [VAL_IN_W-1:0] sample_value;

    modport source (output valid, output mode, output sample_index, output sample_value,
                    input ready);
    modport sink   (input valid, input mode, input sample_index, input sample_value,
                    output ready);
endinterface

interface svrm_out_if;
    import svrm_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] left_out;
    logic signed [OUT_W-1:0] right_out;
    logic                    voice_active;
    logic [LEN_W-1:0]        play_index;

    modport source (output valid, output left_out, output right_out, output voice_active,
                    output play_index, input ready);
    modport sink   (input valid, input left_out, input right_out, input voice_active,
                    input play_index, output ready);
endinterface

/* rtl/svrm_cfg_regs.sv */
// configuration register file of the voice
module svrm_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [svrm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [svrm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output svrm_pkg::t_cfg                    o_cfg
);
    import svrm_pkg::*;

    t_cfg r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sample_length <= RST_SAMPLE_LENGTH;
            r_cfg.loop_enable   <= 1'b0;
            r_cfg.step          <= RST_STEP;
            r_cfg.gain          <= RST_GAIN;
            r_cfg.voice_pan     <= '0;
            r_cfg.channel_pan   <= '0;
            r_cfg.balance       <= '0;
            r_cfg.lead_in       <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SAMPLE_LENGTH: r_cfg.sample_length <= i_cfg_data[LEN_W-1:0];
                REG_LOOP_ENABLE:   r_cfg.loop_enable   <= i_cfg_data[0];
                REG_STEP:          r_cfg.step          <= i_cfg_data[STEP_W-1:0];
                REG_GAIN:          r_cfg.gain          <= i_cfg_data[GAIN_W-1:0];
                REG_VOICE_PAN:     r_cfg.voice_pan     <= i_cfg_data[PAN_W-1:0];
                REG_CHANNEL_PAN:   r_cfg.channel_pan   <= i_cfg_data[PAN_W-1:0];
                REG_BALANCE:       r_cfg.balance       <= i_cfg_data[PAN_W-1:0];
                REG_LEAD_IN:       r_cfg.lead_in       <= i_cfg_data[DELAY_W-1:0];
                default:           r_cfg               <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/svrm_ctrl.sv */
// frame sequencer and output handshake control
module svrm_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic [svrm_pkg::MODE_W-1:0]   i_in_mode,
    output logic                          o_in_ready,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    input  svrm_pkg::t_status             i_status,
    output svrm_pkg::t_cmd                o_cmd
);
    import svrm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_READ,
        S_INTERP,
        S_SCALE,
        S_MIX,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   accept;
    logic   load_out;

    // handshake decode
    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign load_out   = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (accept && i_in_mode == MODE_RENDER) n_state = S_CHECK;
            S_CHECK:  n_state = i_status.frame_silent ? S_DONE : S_READ;
            S_READ:   n_state = S_INTERP;
            S_INTERP: n_state = S_SCALE;
            S_SCALE:  n_state = S_MIX;
            S_MIX:    n_state = S_DONE;
            S_DONE:   if (load_out) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath commands
    always_comb begin
        o_cmd          = '0;
        o_cmd.accept   = accept;
        o_cmd.check    = (r_state == S_CHECK);
        o_cmd.read     = (r_state == S_READ);
        o_cmd.interp   = (r_state == S_INTERP);
        o_cmd.scale    = (r_state == S_SCALE);
        o_cmd.mix      = (r_state == S_MIX);
        o_cmd.load_out = load_out;
    end

    assign o_out_valid = r_out_valid;

endmodule

/* rtl/svrm_datapath.sv */
// voice state, sample memory, interpolation, gain and pan arithmetic
module svrm_datapath #(
    parameter int MAX_SAMPLES = svrm_pkg::DEF_MAX_SAMPLES,
    parameter int SAMPLE_BITS = svrm_pkg::DEF_SAMPLE_BITS,
    parameter int FRAC_BITS   = svrm_pkg::DEF_FRAC_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  svrm_pkg::t_cfg                       i_cfg,
    input  svrm_pkg::t_cmd                       i_cmd,
    output svrm_pkg::t_status                    o_status,
    input  logic [svrm_pkg::MODE_W-1:0]          i_mode,
    input  logic [svrm_pkg::IDX_IN_W-1:0]        i_sample_index,
    input  logic signed [svrm_pkg::VAL_IN_W-1:0] i_sample_value,
    output logic signed [svrm_pkg::OUT_W-1:0]    o_left_out,
    output logic signed [svrm_pkg::OUT_W-1:0]    o_right_out,
    output logic                                 o_voice_active,
    output logic [svrm_pkg::LEN_W-1:0]           o_play_index
);
    import svrm_pkg::*;

    localparam int ADDR_W  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int POS_W   = LEN_W + FRAC_BITS + 1;
    localparam int STP_W   = (POS_W > STEP_W + 1) ? POS_W : STEP_W + 1;
    localparam int EXT_W   = (SAMPLE_BITS > VAL_IN_W) ? SAMPLE_BITS : VAL_IN_W;
    localparam int DIFF_W  = SAMPLE_BITS + 1;
    localparam int PROD_W  = DIFF_W + FRAC_BITS + 1;
    localparam int S_W     = SAMPLE_BITS + 2;
    localparam int SG_W    = S_W + GAIN_W + 1;
    localparam int MIX_W   = SG_W + WEIGHT_W + 1;
    localparam logic signed [MIX_W-1:0] SAT_HI = MIX_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [MIX_W-1:0] SAT_LO = MIX_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

    // voice state
    logic [POS_W-1:0]              r_pos;
    logic                          r_active;
    logic [DELAY_W-1:0]            r_delay;

    // frame pipeline registers
    logic                          r_silent;
    logic                          r_act_res;
    logic signed [SAMPLE_BITS-1:0] r_s0;
    logic signed [SAMPLE_BITS-1:0] r_s1;
    logic [FRAC_BITS-1:0]          r_frac;
    logic [POS_W-1:0]              r_stp;
    logic [POS_W-1:0]              r_sum;
    logic [WEIGHT_W-1:0]           r_wl;
    logic [WEIGHT_W-1:0]           r_wr;
    logic signed [PROD_W-1:0]      r_prod;
    logic signed [SG_W-1:0]        r_sg;
    logic signed [MIX_W-1:0]       r_left;
    logic signed [MIX_W-1:0]       r_right;

    // output payload
    logic signed [OUT_W-1:0]       r_left_out;
    logic signed [OUT_W-1:0]       r_right_out;
    logic                          r_voice_active;
    logic [LEN_W-1:0]              r_play_index;

    // sample memory
    logic signed [SAMPLE_BITS-1:0] r_mem [MAX_SAMPLES];

    logic [LEN_W-1:0]              eff_len;
    logic [POS_W-1:0]              end_pos;
    logic [POS_W-1:0]              pos_wrap;
    logic                          at_end;
    logic                          silent;
    logic                          mem_we;
    logic [ADDR_W-1:0]             wr_addr;
    logic signed [EXT_W-1:0]       wr_ext;
    logic [LEN_W-1:0]              rd_idx;
    logic [LEN_W:0]                rd_nxt_full;
    logic [LEN_W-1:0]              rd_nxt;
    logic [STP_W-1:0]              stp_raw;
    logic [STP_W-1:0]              end_wide;
    logic signed [PAN_SUM_W-1:0]   pan_sum;
    logic signed [PAN_SUM_W-1:0]   pan_clamp;
    logic signed [PAN_SUM_W-1:0]   wl_full;
    logic signed [PAN_SUM_W-1:0]   wr_full;
    logic signed [DIFF_W-1:0]      diff;
    logic signed [S_W-1:0]         interp;
    logic [LEN_W:0]                pos_idx;
    logic [LEN_W-1:0]              play_idx;

    // saturate a mixed value to the sample range and fit it to the output field
    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [MIX_W-1:0] v);
        logic signed [MIX_W-1:0]       shifted;
        logic signed [MIX_W-1:0]       clipped;
        logic signed [SAMPLE_BITS-1:0] narrow;
        shifted = v >>> MIX_SHIFT;
        if (shifted > SAT_HI) begin
            clipped = SAT_HI;
        end else if (shifted < SAT_LO) begin
            clipped = SAT_LO;
        end else begin
            clipped = shifted;
        end
        narrow  = clipped[SAMPLE_BITS-1:0];
        return OUT_W'(narrow);
    endfunction

    // effective length and end position
    assign eff_len = (32'(i_cfg.sample_length) > MAX_SAMPLES) ? LEN_W'(MAX_SAMPLES)
                                                               : i_cfg.sample_length;
    assign end_pos = POS_W'(eff_len) << FRAC_BITS;
    assign at_end  = (r_pos >= end_pos);

    // silent frame decision and loop wrap
    assign silent   = !r_active || (r_delay != '0) || (eff_len == '0)
                      || (at_end && !i_cfg.loop_enable);
    assign pos_wrap = r_pos - end_pos;
    assign o_status.frame_silent = silent;

    // voice state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_active <= 1'b0;
            r_delay  <= '0;
        end else if (i_cmd.accept && i_mode == MODE_START) begin
            r_pos    <= '0;
            r_active <= 1'b1;
            r_delay  <= i_cfg.lead_in;
        end else if (i_cmd.check) begin
            if (r_active) begin
                if (r_delay != '0) begin
                    r_delay <= r_delay - 1'b1;
                end else if (eff_len == '0) begin
                    r_active <= 1'b0;
                end else if (at_end) begin
                    if (!i_cfg.loop_enable) begin
                        r_active <= 1'b0;
                    end else begin
                        r_pos <= (pos_wrap >= end_pos) ? '0 : pos_wrap;
                    end
                end
            end
        end else if (i_cmd.scale) begin
            if (r_sum >= end_pos) begin
                r_pos <= i_cfg.loop_enable ? (r_sum - end_pos) : end_pos;
            end else begin
                r_pos <= r_sum;
            end
        end
    end

    // sample memory write
    assign mem_we  = i_cmd.accept && (i_mode == MODE_WRITE)
                     && (32'(i_sample_index) < MAX_SAMPLES);
    assign wr_addr = ADDR_W'(i_sample_index);
    assign wr_ext  = EXT_W'(i_sample_value);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_ext[SAMPLE_BITS-1:0];
        end
    end

    // read addresses for the current and next sample
    assign rd_idx      = r_pos[FRAC_BITS +: LEN_W];
    assign rd_nxt_full = {1'b0, rd_idx} + 1'b1;
    assign rd_nxt      = (rd_nxt_full >= {1'b0, eff_len})
                         ? (i_cfg.loop_enable ? '0 : rd_idx)
                         : rd_nxt_full[LEN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_s0 <= r_mem[ADDR_W'(rd_idx)];
            r_s1 <= r_mem[ADDR_W'(rd_nxt)];
        end
    end

    // step limit below the end
    assign stp_raw  = (i_cfg.step == '0) ? (STP_W'(1) << FRAC_BITS) : STP_W'(i_cfg.step);
    assign end_wide = STP_W'(end_pos);

    // pan weights
    assign pan_sum   = PAN_SUM_W'(i_cfg.voice_pan) + PAN_SUM_W'(i_cfg.channel_pan)
                       + PAN_SUM_W'(i_cfg.balance);
    assign pan_clamp = (pan_sum < -PAN_SUM_W'(PAN_ONE)) ? -PAN_SUM_W'(PAN_ONE)
                     : (pan_sum > PAN_SUM_W'(PAN_ONE))  ? PAN_SUM_W'(PAN_ONE)
                     : pan_sum;
    assign wl_full   = PAN_SUM_W'(PAN_ONE) - pan_clamp;
    assign wr_full   = PAN_SUM_W'(PAN_ONE) + pan_clamp;

    // per-frame operands
    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_frac <= r_pos[FRAC_BITS-1:0];
            r_stp  <= (stp_raw >= end_wide) ? POS_W'(end_wide - 1'b1) : POS_W'(stp_raw);
            r_wl   <= wl_full[WEIGHT_W-1:0];
            r_wr   <= wr_full[WEIGHT_W-1:0];
        end
    end

    // interpolation product and position advance
    assign diff = DIFF_W'(r_s1) - DIFF_W'(r_s0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.interp) begin
            r_prod <= diff * $signed({1'b0, r_frac});
            r_sum  <= r_pos + r_stp;
        end
    end

    // interpolated sample times gain
    assign interp = S_W'(r_s0) + S_W'(r_prod >>> FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (i_cmd.scale) begin
            r_sg <= interp * $signed({1'b0, i_cfg.gain});
        end
    end

    // left and right weighting
    always_ff @(posedge i_clk) begin
        if (i_cmd.mix) begin
            r_left  <= r_sg * $signed({1'b0, r_wl});
            r_right <= r_sg * $signed({1'b0, r_wr});
        end
    end

    // frame status flags
    always_ff @(posedge i_clk) begin
        if (i_cmd.check) begin
            r_silent  <= silent;
            r_act_res <= !silent || (r_active && r_delay != '0);
        end
    end

    // integer play position, held at the length past the end
    assign pos_idx  = r_pos[POS_W-1:FRAC_BITS];
    assign play_idx = (pos_idx >= {1'b0, eff_len}) ? eff_len : pos_idx[LEN_W-1:0];

    // output payload register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_left_out     <= r_silent ? '0 : sat_out(r_left);
            r_right_out    <= r_silent ? '0 : sat_out(r_right);
            r_voice_active <= r_act_res;
            r_play_index   <= play_idx;
        end
    end

    assign o_left_out     = r_left_out;
    assign o_right_out    = r_right_out;
    assign o_voice_active = r_voice_active;
    assign o_play_index   = r_play_index;

endmodule

/* rtl/sample_voice_resampling_mixer_core.sv */
// top level of the sampled voice with linear interpolation and stereo pan
//
// One sampled voice. Input transactions carry a mode: sample word write and voice start
// are taken while the controller stays idle; a render transaction produces one stereo
// result transaction. A render runs from acceptance to the output register through a
// check step, a memory read on the dual read port sample memory, an interpolation
// multiply, a gain multiply, a pan weighting multiply and a saturation step; a silent
// frame (inactive voice, start delay running, zero length, end of a one-shot) skips the
// arithmetic and goes from check straight to the output load. The controller accepts the next
// transaction as soon as it returns to idle, while a finished result may still wait in
// the output register. Configuration writes take effect at the clock edge of the write
// enable; the user must make them only while the voice is idle, unenforced by the block.
module sample_voice_resampling_mixer_core #(
    parameter int MAX_SAMPLES = svrm_pkg::DEF_MAX_SAMPLES,
    parameter int SAMPLE_BITS = svrm_pkg::DEF_SAMPLE_BITS,
    parameter int FRAC_BITS   = svrm_pkg::DEF_FRAC_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [svrm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [svrm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    svrm_in_if.sink                          i_in,
    svrm_out_if.source                       o_out
);
    import svrm_pkg::*;

    t_cfg    cfg;
    t_cmd    cmd;
    t_status status;
    logic    in_ready;
    logic    out_valid;

    // configuration registers
    svrm_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // frame sequencer
    svrm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_mode   (i_in.mode),
        .o_in_ready  (in_ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (out_valid),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // voice datapath
    svrm_datapath #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_mode         (i_in.mode),
        .i_sample_index (i_in.sample_index),
        .i_sample_value (i_in.sample_value),
        .o_left_out     (o_out.left_out),
        .o_right_out    (o_out.right_out),
        .o_voice_active (o_out.voice_active),
        .o_play_index   (o_out.play_index)
    );

    // channel handshakes
    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

endmodule
